>>> rtl/core/fmqd_pkg.sv
// Shared types and constants of the FM quadrature demodulator.
package fmqd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned GAIN_W = 16;

    // pi/4 and 3*pi/4 with 30 fraction bits
    localparam logic [DATA_W-1:0] PI4_Q30  = 32'd843314856;
    localparam logic [DATA_W-1:0] PI34_Q30 = 32'd2529944569;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RE_A,
        ST_RE_B,
        ST_IM_A,
        ST_IM_B,
        ST_IM_SUM,
        ST_AY,
        ST_DIV_PREP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ANGLE,
        ST_SCALE,
        ST_GAIN,
        ST_DONE
    } fmqd_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } fmqd_div_req_t;

endpackage

>>> rtl/core/fm_quadrature_demodulator.sv
// Top level of the FM quadrature demodulator with a one-division arctangent.
//
// Usage:
//   Input channel: sample_real / sample_imag with sample_valid and sample_stall.
//   A request is taken at a rising edge with sample_valid high and sample_stall
//   low. Each request gives exactly one demod_value request on the output
//   channel (demod_valid / demod_stall), the phase step between this sample and
//   the previous one, scaled by demod_gain and shifted right by FRAC_BITS.
//   demod_gain is to be written with demod_gain_we / demod_gain_data while idle; not enforced.
//
// Processing and throughput:
//   A sample passes through the serial divider (32 steps plus setup and sign fix)
//   and makes six passes through the one shared 32x32 multiplier. sample_stall
//   is high from acceptance until the result is written to the output register,
//   so no new sample is taken before the block is through with the last one.
//
// Reset: the previous sample is cleared to (0, 0), demod_gain returns to 758,
//   the output is empty and the block is ready at once.
// Receiver stall: the result is held in the output register. The block takes
//   the next sample meanwhile, and holds its finished result until the output
//   register frees.
module fm_quadrature_demodulator #(
    parameter int unsigned FRAC_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                demod_gain_we,
    input  logic [fmqd_pkg::GAIN_W-1:0]         demod_gain_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [fmqd_pkg::DATA_W-1:0]  sample_real,
    input  logic signed [fmqd_pkg::DATA_W-1:0]  sample_imag,
    output logic                                demod_valid,
    input  logic                                demod_stall,
    output logic signed [fmqd_pkg::DATA_W-1:0]  demod_value
);

    localparam int unsigned W = fmqd_pkg::DATA_W;
    localparam logic [W-1:0] Q1 = fmqd_pkg::PI4_Q30 >> (30 - FRAC_BITS);
    localparam logic [W-1:0] Q3 = fmqd_pkg::PI34_Q30 >> (30 - FRAC_BITS);
    localparam logic [fmqd_pkg::GAIN_W-1:0] GAIN_RESET = 16'd758;

    fmqd_pkg::fmqd_state_t state_reg, state_next;

    logic [fmqd_pkg::GAIN_W-1:0] gain_reg;
    logic [W-1:0] last_real_reg, last_real_next;
    logic [W-1:0] last_imag_reg, last_imag_next;
    logic [W-1:0] cur_real_reg, cur_real_next;
    logic [W-1:0] cur_imag_reg, cur_imag_next;
    logic [W-1:0] npq_reg, npq_next;
    logic [W-1:0] re_reg, re_next;
    logic [W-1:0] im_reg, im_next;
    logic [W-1:0] ay_reg, ay_next;
    logic [W-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    logic [W-1:0] ang_reg, ang_next;
    logic [W-1:0] out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    logic [W-1:0] op_a, op_b, product, prod_asr;
    logic [W-1:0] quotient;
    logic         div_done;
    logic         out_free;
    fmqd_pkg::fmqd_div_req_t div_req;

    fmqd_mul u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    fmqd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    assign prod_asr = W'($signed(product) >>> FRAC_BITS);
    assign out_free = !out_valid_reg || !demod_stall;

    always_comb
    begin
        state_next     = state_reg;
        last_real_next = last_real_reg;
        last_imag_next = last_imag_reg;
        cur_real_next  = cur_real_reg;
        cur_imag_next  = cur_imag_reg;
        npq_next       = npq_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        ay_next        = ay_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        ang_next       = ang_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && demod_stall;
        op_a           = last_real_reg;
        op_b           = cur_real_reg;
        div_req.start  = 1'b0;
        div_req.num    = num_reg;
        div_req.den    = den_reg;

        case (state_reg)
            fmqd_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cur_real_next = sample_real;
                    cur_imag_next = sample_imag;
                    npq_next      = ~last_imag_reg + 1'b1;
                    state_next    = fmqd_pkg::ST_RE_A;
                end
            end
            fmqd_pkg::ST_RE_A:
            begin
                // issue pr*r
                state_next = fmqd_pkg::ST_RE_B;
            end
            fmqd_pkg::ST_RE_B:
            begin
                op_a       = npq_reg;
                op_b       = cur_imag_reg;
                re_next    = prod_asr;
                state_next = fmqd_pkg::ST_IM_A;
            end
            fmqd_pkg::ST_IM_A:
            begin
                op_a       = last_real_reg;
                op_b       = cur_imag_reg;
                re_next    = re_reg - prod_asr;
                state_next = fmqd_pkg::ST_IM_B;
            end
            fmqd_pkg::ST_IM_B:
            begin
                op_a       = npq_reg;
                op_b       = cur_real_reg;
                im_next    = prod_asr;
                state_next = fmqd_pkg::ST_IM_SUM;
            end
            fmqd_pkg::ST_IM_SUM:
            begin
                im_next    = im_reg + prod_asr;
                state_next = fmqd_pkg::ST_AY;
            end
            fmqd_pkg::ST_AY:
            begin
                // |im| + 1 in one add; the most negative im wraps
                ay_next    = im_reg[W-1] ? (~im_reg + W'(2)) : (im_reg + W'(1));
                state_next = fmqd_pkg::ST_DIV_PREP;
            end
            fmqd_pkg::ST_DIV_PREP:
            begin
                if (!re_reg[W-1])
                begin
                    num_next = W'((re_reg - ay_reg) << FRAC_BITS);
                    den_next = re_reg + ay_reg;
                end
                else
                begin
                    num_next = W'((re_reg + ay_reg) << FRAC_BITS);
                    den_next = ay_reg - re_reg;
                end
                state_next = fmqd_pkg::ST_DIV_START;
            end
            fmqd_pkg::ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = fmqd_pkg::ST_DIV_WAIT;
            end
            fmqd_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = fmqd_pkg::ST_ANGLE;
            end
            fmqd_pkg::ST_ANGLE:
            begin
                op_a       = Q1;
                op_b       = quotient;
                state_next = fmqd_pkg::ST_SCALE;
            end
            fmqd_pkg::ST_SCALE:
            begin
                // base minus correction, negated for a negative im
                if (im_reg[W-1])
                    ang_next = prod_asr - (re_reg[W-1] ? Q3 : Q1);
                else
                    ang_next = (re_reg[W-1] ? Q3 : Q1) - prod_asr;
                state_next = fmqd_pkg::ST_GAIN;
            end
            fmqd_pkg::ST_GAIN:
            begin
                op_a       = W'(gain_reg);
                op_b       = ang_reg;
                state_next = fmqd_pkg::ST_DONE;
            end
            fmqd_pkg::ST_DONE:
            begin
                // keep the product steady while the output register is full
                op_a = W'(gain_reg);
                op_b = ang_reg;
                if (out_free)
                begin
                    out_next       = prod_asr;
                    out_valid_next = 1'b1;
                    last_real_next = cur_real_reg;
                    last_imag_next = cur_imag_reg;
                    state_next     = fmqd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmqd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmqd_pkg::ST_IDLE;
            gain_reg      <= GAIN_RESET;
            last_real_reg <= '0;
            last_imag_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_real_reg <= last_real_next;
            last_imag_reg <= last_imag_next;
            out_valid_reg <= out_valid_next;
            if (demod_gain_we)
                gain_reg <= demod_gain_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_real_reg <= cur_real_next;
        cur_imag_reg <= cur_imag_next;
        npq_reg      <= npq_next;
        re_reg       <= re_next;
        im_reg       <= im_next;
        ay_reg       <= ay_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        ang_reg      <= ang_next;
        out_reg      <= out_next;
    end

    assign sample_stall = (state_reg != fmqd_pkg::ST_IDLE);
    assign demod_valid  = out_valid_reg;
    assign demod_value  = out_reg;

endmodule

>>> rtl/core/fmqd_mul.sv
// Shared 32x32 multiplier, low half of the product, registered.
module fmqd_mul (
    input  logic                          clk,
    input  logic [fmqd_pkg::DATA_W-1:0]   op_a,
    input  logic [fmqd_pkg::DATA_W-1:0]   op_b,
    output logic [fmqd_pkg::DATA_W-1:0]   product
);

    logic [fmqd_pkg::DATA_W-1:0] prod_reg;

    // wraps to the word width
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign product = prod_reg;

endmodule

>>> rtl/core/fmqd_div.sv
// Bit-serial signed divider, truncating toward zero, zero divisor gives zero.
module fmqd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmqd_pkg::fmqd_div_req_t       req,
    output logic                          done,
    output logic [fmqd_pkg::DATA_W-1:0]   quotient
);

    localparam int unsigned W  = fmqd_pkg::DATA_W;
    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          fix_reg, fix_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  result_reg, result_next;

    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        trial       = {rem_reg, quo_reg[W-1]};
        diff        = trial - {1'b0, dmag_reg};
        busy_next   = busy_reg;
        fix_next    = 1'b0;
        done_next   = done_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dmag_next   = dmag_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            count_next = CW'(W - 1);
            rem_next   = '0;
            quo_next   = req.num[W-1] ? (~req.num + 1'b1) : req.num;
            dmag_next  = req.den[W-1] ? (~req.den + 1'b1) : req.den;
            neg_next   = req.num[W-1] ^ req.den[W-1];
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            // apply sign, force zero for a zero divisor
            if (dmag_reg == '0)
                result_next = '0;
            else if (neg_reg)
                result_next = ~quo_reg + 1'b1;
            else
                result_next = quo_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fix_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            fix_reg   <= fix_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done     = done_reg;
    assign quotient = result_reg;

endmodule

>>> rtl/core/fmqd_checker.sv
// Port-level checks of the FM quadrature demodulator and their binding.
module fmqd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_stall,
    input logic                                demod_valid,
    input logic                                demod_stall,
    input logic signed [fmqd_pkg::DATA_W-1:0]  demod_value
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        demod_valid && demod_stall |=> demod_valid && $stable(demod_value))
    else $error("stalled result changed");

    // one sample at a time: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
    else $error("input not stalled after a request");

    // a new result is only posted at the end of the work on a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(demod_valid) |-> $past(sample_stall))
    else $error("result posted while idle");

    // no result can follow a request too early
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |-> ##2 !$rose(demod_valid))
    else $error("result too early");

endmodule

bind fm_quadrature_demodulator fmqd_checker u_fmqd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .demod_valid  (demod_valid),
    .demod_stall  (demod_stall),
    .demod_value  (demod_value)
);

>>> bench/tb_top.sv
// Self-checking testbench for the FM quadrature demodulator with its own phase-step predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DATA_W = fmqd_pkg::DATA_W;
    localparam int unsigned GAIN_W = fmqd_pkg::GAIN_W;
    localparam logic [DATA_W-1:0] PI4_Q30  = fmqd_pkg::PI4_Q30;
    localparam logic [DATA_W-1:0] PI34_Q30 = fmqd_pkg::PI34_Q30;

    localparam int unsigned FRAC_BITS    = 10;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 119;
    // Leave room for a late stray request after the last result.
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam logic [GAIN_W-1:0] RESET_GAIN = 16'd758;

    // A zero current sample always gives re = im = 0, so the angle is pi/2
    // (twice the quarter-pi constant) and the reset gain scales it to 1190.
    localparam logic [DATA_W-1:0] ZERO_STEP = 32'd1190;

    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE   = 32'd1024;
    localparam logic [DATA_W-1:0] M_ONE = 32'hFFFF_FC00;

    // One row of the directed table: a sample and, where it is obvious,
    // the demod value it must produce.
    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              known;
        logic [DATA_W-1:0] value;
    } sample_row_t;

    localparam int unsigned DIR_ROWS = 22;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic demod_gain_we = 1'b0;
    logic [GAIN_W-1:0] demod_gain_data = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [DATA_W-1:0] sample_real = '0;
    logic signed [DATA_W-1:0] sample_imag = '0;
    logic demod_valid;
    logic demod_stall = 1'b0;
    logic signed [DATA_W-1:0] demod_value;

    // Predictor state: previous sample and the gain the block holds.
    logic [DATA_W-1:0] prev_real = '0;
    logic [DATA_W-1:0] prev_imag = '0;
    logic [GAIN_W-1:0] gain_now = RESET_GAIN;

    logic [DATA_W-1:0] pending_steps [$];
    sample_row_t       dir_table [DIR_ROWS];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;

    fm_quadrature_demodulator #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .demod_gain_we   (demod_gain_we),
        .demod_gain_data (demod_gain_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample_real     (sample_real),
        .sample_imag     (sample_imag),
        .demod_valid     (demod_valid),
        .demod_stall     (demod_stall),
        .demod_value     (demod_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Arithmetic shift right by the fraction width.
    function automatic logic [DATA_W-1:0] shr_frac(input logic [DATA_W-1:0] v);
        return $signed(v) >>> FRAC_BITS;
    endfunction

    // Signed division truncating toward zero; a zero divisor yields zero.
    function automatic logic [DATA_W-1:0] div_trunc(input logic [DATA_W-1:0] n,
                                                    input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] un;
        logic [DATA_W-1:0] ud;
        logic [DATA_W-1:0] q;
        un = n[DATA_W-1] ? 32'd0 - n : n;
        ud = d[DATA_W-1] ? 32'd0 - d : d;
        if (ud == 32'd0)
            return 32'd0;
        q = un / ud;
        return (n[DATA_W-1] != d[DATA_W-1]) ? 32'd0 - q : q;
    endfunction

    // Phase step between two samples, scaled by the gain; every operation
    // wraps at 32 bits.
    function automatic logic [DATA_W-1:0] predict_phase_step(
        input logic [DATA_W-1:0] cur_re,
        input logic [DATA_W-1:0] cur_im,
        input logic [DATA_W-1:0] old_re,
        input logic [DATA_W-1:0] old_im,
        input logic [GAIN_W-1:0] gain
    );
        logic [DATA_W-1:0] neg_old_im;
        logic [DATA_W-1:0] p_a;
        logic [DATA_W-1:0] p_b;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic [DATA_W-1:0] q1;
        logic [DATA_W-1:0] q3;
        logic [DATA_W-1:0] ay;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] ratio;
        logic [DATA_W-1:0] corr;
        logic [DATA_W-1:0] ang;
        logic [DATA_W-1:0] scaled;
        neg_old_im = 32'd0 - old_im;
        p_a = old_re * cur_re;
        p_b = neg_old_im * cur_im;
        re  = shr_frac(p_a) - shr_frac(p_b);
        p_a = old_re * cur_im;
        p_b = neg_old_im * cur_re;
        im  = shr_frac(p_a) + shr_frac(p_b);
        q1 = PI4_Q30 >> (30 - FRAC_BITS);
        q3 = PI34_Q30 >> (30 - FRAC_BITS);
        ay = (im[DATA_W-1] ? 32'd0 - im : im) + 32'd1;
        if (!re[DATA_W-1])
        begin
            num = (re - ay) << FRAC_BITS;
            den = re + ay;
        end
        else
        begin
            num = (re + ay) << FRAC_BITS;
            den = ay - re;
        end
        ratio = div_trunc(num, den);
        corr  = q1 * ratio;
        ang   = (re[DATA_W-1] ? q3 : q1) - shr_frac(corr);
        if (im[DATA_W-1])
            ang = 32'd0 - ang;
        scaled = {16'd0, gain} * ang;
        return shr_frac(scaled);
    endfunction

    // Pick one of the corner values of a sample component.
    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return S_MAX;
            4: return S_MIN;
            5: return ONE;
            6: return M_ONE;
            default: return 32'h0000_7FFF;
        endcase
    endfunction

    // Drive one sample request, wait for acceptance, record the expected
    // step, then idle at random.
    task automatic send_sample(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                               input logic known, input logic [DATA_W-1:0] typed);
        logic [DATA_W-1:0] step;
        sample_real  <= re;
        sample_imag  <= im;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        step = predict_phase_step(re, im, prev_real, prev_imag, gain_now);
        prev_real = re;
        prev_imag = im;
        pending_steps.push_back(known ? typed : step);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Write the gain only once the block has drained every request.
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        sample_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        @(posedge clk);
        demod_gain_we   <= 1'b1;
        demod_gain_data <= g;
        @(posedge clk);
        demod_gain_we <= 1'b0;
        gain_now = g;
    endtask

    // Random traffic: mostly rotating phasors, as a real FM signal looks,
    // plus raw noise and corner values.
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned kind;
        int unsigned k;
        real amp;
        real ph;
        real dph;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                burst = $urandom_range(4, 40);
                if (burst > count - sent)
                    burst = count - sent;
                amp = real'($urandom_range(1, 1 << $urandom_range(4, 20)));
                ph  = real'($urandom_range(0, 6283)) / 1000.0;
                dph = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 3.1;
                for (k = 0; k < burst; k++)
                begin
                    re = $rtoi(amp * $cos(ph));
                    im = $rtoi(amp * $sin(ph));
                    send_sample(re, im, 1'b0, '0);
                    ph = ph + dph;
                end
                sent += burst;
            end
            else if (kind < 90)
            begin
                send_sample($urandom, $urandom, 1'b0, '0);
                sent++;
            end
            else
            begin
                send_sample(corner_value(), corner_value(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver: stall at the rate of the current phase.
    always @(posedge clk)
    begin
        demod_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Check each accepted result against the oldest expected step.
    always @(posedge clk)
    begin
        if (rst_n && demod_valid && !demod_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                $error("demod_value: unexpected request, actual %0d", demod_value);
                fail_count++;
            end
            else if (demod_value !== pending_steps[0])
            begin
                $error("demod_value: expected %0d, actual %0d",
                       $signed(pending_steps[0]), demod_value);
                fail_count++;
                void'(pending_steps.pop_front());
            end
            else
            begin
                void'(pending_steps.pop_front());
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        logic [GAIN_W-1:0] phase_gain;
        int unsigned row;
        int unsigned ph;

        dir_table = '{
            '{32'd0,        32'd0,        1'b1, ZERO_STEP},  // reset: previous is zero
            '{32'd0,        32'd0,        1'b1, ZERO_STEP},
            '{S_MAX,        S_MAX,        1'b1, ZERO_STEP},  // previous still zero
            '{S_MIN,        S_MIN,        1'b0, 32'd0},
            '{32'd0,        32'd0,        1'b1, ZERO_STEP},  // zero current sample
            '{S_MIN,        S_MAX,        1'b0, 32'd0},
            '{S_MAX,        S_MIN,        1'b0, 32'd0},
            '{32'd0,        32'd0,        1'b1, ZERO_STEP},
            '{ONE,          32'd0,        1'b1, ZERO_STEP},  // previous zero again
            '{32'd0,        ONE,          1'b0, 32'd0},      // quarter turns
            '{M_ONE,        32'd0,        1'b0, 32'd0},
            '{32'd0,        M_ONE,        1'b0, 32'd0},
            '{ONE,          32'd0,        1'b0, 32'd0},
            '{M_ONE,        32'd0,        1'b0, 32'd0},      // half turn, re < 0
            '{32'd1,        32'd1,        1'b0, 32'd0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0},
            '{32'd1,        32'hFFFF_FFFF, 1'b0, 32'd0},
            '{32'h7FFF_FC00, ONE,         1'b0, 32'd0},      // shifted ratio wraps
            '{S_MIN,        32'd1,        1'b0, 32'd0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'd0},
            '{32'd0,        32'd0,        1'b1, ZERO_STEP}
        };

        // Hold reset at the start, then release it once.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset gain.
        tx_idle_pct = 29;
        rx_idle_pct = 78;
        for (row = 0; row < DIR_ROWS; row++)
            send_sample(dir_table[row].re, dir_table[row].im,
                        dir_table[row].known, dir_table[row].value);

        // Random phases: new gain each phase, idling swapped between sides
        // from phase 3 on, then none at all from phase 6.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: phase_gain = 16'd0;
                1: phase_gain = 16'hFFFF;
                2: phase_gain = 16'd1;
                3: phase_gain = RESET_GAIN;
                5: phase_gain = 16'h8000;
                7: phase_gain = 16'hFFFF;
                default: phase_gain = GAIN_W'($urandom);
            endcase
            write_gain(phase_gain);
            if (ph < 3)
            begin
                tx_idle_pct = 29;
                rx_idle_pct = 78;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 29;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_random(PHASE_ITEMS);
        end

        // Drop valid, drain, and give stray requests time to show up.
        sample_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/fmqd_pkg.sv
rtl/core/fmqd_mul.sv
rtl/core/fmqd_div.sv
rtl/core/fm_quadrature_demodulator.sv
rtl/core/fmqd_checker.sv
bench/tb_top.sv
